>>> src/deq_pkg.sv
// Package: item, entry and code definitions for the deadline expiration queue.
package deq_pkg;

   localparam int ID_W   = 32;
   localparam int TIME_W = 48;
   localparam int ORD_W  = 16;
   localparam int LIM_W  = 7;
   localparam int CSR_W  = 32;

   typedef enum logic [1:0] {
      REQ_SET     = 2'd0,
      REQ_DESTROY = 2'd1,
      REQ_FAILED  = 2'd2,
      REQ_CHECK   = 2'd3
   } req_code_type;

   typedef enum logic {
      CSR_MAX_REMOVALS = 1'b0,
      CSR_BACKOFF_TIME = 1'b1
   } csr_index_type;

   localparam logic STATUS_EXPIRED = 1'b0;
   localparam logic STATUS_FULL    = 1'b1;

   localparam logic [LIM_W-1:0]  MAX_REMOVALS_RST = 7'd64;
   localparam logic [CSR_W-1:0]  BACKOFF_RST      = 32'd1000000;

   typedef struct packed {
      req_code_type        req_type;
      logic [ID_W-1:0]     node_id;
      logic                has_time;
      logic [TIME_W-1:0]   expire_time;
      logic [TIME_W-1:0]   now;
      logic                leader_active;
   } req_item_type;

   typedef struct packed {
      logic [ID_W-1:0] out_node_id;
      logic            status;
      logic            last;
   } rsp_item_type;

   typedef struct packed {
      logic              valid;
      logic [ID_W-1:0]   node;
      logic [TIME_W-1:0] deadline;
      logic [ORD_W-1:0]  order;
   } entry_type;

endpackage

>>> src/deadline_expiration_queue.sv
// Top level: deadline table with a sequenced scan over a table memory with one read and one write port.
// Set, destroy and removal-failed items are handled one item at a time.
// A check tick emits up to the batch limit of expired ids, with a full scan for each;
// it starts no scan when not leader or the limit is zero. A stalled result holds the sequence.
// Each scan reads one entry per cycle; results wait in one output register.
// Reset: synchronous; a clearing pass over all ENTRIES entries follows, with req_stall held high.
module deadline_expiration_queue #(
   parameter int ENTRIES   = 64,
   parameter int MAX_BATCH = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  deq_pkg::req_item_type  req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output deq_pkg::rsp_item_type  rsp_item,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  deq_pkg::csr_index_type csr_index,
   input  logic [deq_pkg::CSR_W-1:0] csr_data
);
   import deq_pkg::*;

   localparam int AW = $clog2(ENTRIES);

   typedef enum logic [7:0] {
      ST_CLEAR = 8'b0000_0001,
      ST_IDLE  = 8'b0000_0010,
      ST_SCAN  = 8'b0000_0100,
      ST_DROP  = 8'b0000_1000,
      ST_ADD   = 8'b0001_0000,
      ST_FULL  = 8'b0010_0000,
      ST_TAKE  = 8'b0100_0000,
      ST_FINAL = 8'b1000_0000
   } state_type;

   state_type          state_ff, state_in;
   req_item_type       cur_ff, cur_in;
   logic [TIME_W-1:0]  cand_dl_ff, cand_dl_in;
   logic [AW:0]        iss_ff, iss_in;
   logic               chk_vld_ff, chk_vld_in;
   logic [AW-1:0]      chk_idx_ff, chk_idx_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic               match_fnd_ff, match_fnd_in;
   logic [AW-1:0]      match_idx_ff, match_idx_in;
   logic               free_fnd_ff, free_fnd_in;
   logic [AW-1:0]      free_idx_ff, free_idx_in;
   logic               best_fnd_ff, best_fnd_in;
   logic [AW-1:0]      best_idx_ff, best_idx_in;
   logic [TIME_W-1:0]  best_dl_ff, best_dl_in;
   logic [ORD_W-1:0]   best_age_ff, best_age_in;
   logic [ID_W-1:0]    best_node_ff, best_node_in;
   logic               pend_vld_ff, pend_vld_in;
   logic [ID_W-1:0]    pend_node_ff, pend_node_in;
   logic [LIM_W-1:0]   count_ff, count_in;
   logic [ORD_W-1:0]   order_ctr_ff, order_ctr_in;
   logic [LIM_W-1:0]   max_rem_ff, max_rem_in;
   logic [CSR_W-1:0]   backoff_ff, backoff_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_item_type       rsp_item_ff, rsp_item_in;

   entry_type          entry_mem [ENTRIES];
   entry_type          rd_data_ff;
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   entry_type          mem_wdata;

   logic [LIM_W-1:0]   limit;
   logic               out_free;
   logic               issuing;
   logic               scan_done;
   logic [ORD_W-1:0]   age;
   logic [TIME_W:0]    backoff_sum;
   logic               slot_fnd;
   logic [AW-1:0]      slot_idx;
   logic               start_scan;

   assign limit     = (max_rem_ff > LIM_W'(MAX_BATCH)) ? LIM_W'(MAX_BATCH) : max_rem_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign issuing   = (state_ff == ST_SCAN) && (iss_ff != (AW+1)'(ENTRIES));
   assign scan_done = (state_ff == ST_SCAN) && (iss_ff == (AW+1)'(ENTRIES)) && !chk_vld_ff;
   assign age       = order_ctr_ff - rd_data_ff.order;
   assign backoff_sum = {1'b0, req_item.now} + (TIME_W+1)'(backoff_ff);
   assign slot_fnd  = free_fnd_ff || match_fnd_ff;
   assign slot_idx  = (match_fnd_ff && (!free_fnd_ff || match_idx_ff < free_idx_ff))
                      ? match_idx_ff : free_idx_ff;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;
   assign csr_ready = 1'b1;

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      cand_dl_in    = cand_dl_ff;
      iss_in        = iss_ff;
      chk_vld_in    = 1'b0;
      chk_idx_in    = chk_idx_ff;
      clr_in        = clr_ff;
      match_fnd_in  = match_fnd_ff;
      match_idx_in  = match_idx_ff;
      free_fnd_in   = free_fnd_ff;
      free_idx_in   = free_idx_ff;
      best_fnd_in   = best_fnd_ff;
      best_idx_in   = best_idx_ff;
      best_dl_in    = best_dl_ff;
      best_age_in   = best_age_ff;
      best_node_in  = best_node_ff;
      pend_vld_in   = pend_vld_ff;
      pend_node_in  = pend_node_ff;
      count_in      = count_ff;
      order_ctr_in  = order_ctr_ff;
      max_rem_in    = max_rem_ff;
      backoff_in    = backoff_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_item_in   = rsp_item_ff;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_wdata     = '0;
      start_scan    = 1'b0;

      if (csr_valid) begin
         case (csr_index)
            CSR_MAX_REMOVALS: max_rem_in = csr_data[LIM_W-1:0];
            CSR_BACKOFF_TIME: backoff_in = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == AW'(ENTRIES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cur_in = req_item;
               if (req_item.req_type == REQ_FAILED) begin
                  cand_dl_in = backoff_sum[TIME_W] ? '1 : backoff_sum[TIME_W-1:0];
               end else begin
                  cand_dl_in = req_item.expire_time;
               end
               pend_vld_in = 1'b0;
               count_in    = '0;
               if (req_item.req_type != REQ_CHECK ||
                   (req_item.leader_active && limit != '0)) begin
                  start_scan = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            if (issuing) begin
               iss_in     = iss_ff + 1'b1;
               chk_vld_in = 1'b1;
               chk_idx_in = iss_ff[AW-1:0];
            end
            if (chk_vld_ff) begin
               if (rd_data_ff.valid && rd_data_ff.node == cur_ff.node_id) begin
                  match_fnd_in = 1'b1;
                  match_idx_in = chk_idx_ff;
               end
               if (!rd_data_ff.valid && !free_fnd_ff) begin
                  free_fnd_in = 1'b1;
                  free_idx_in = chk_idx_ff;
               end
               if (rd_data_ff.valid && (!best_fnd_ff || rd_data_ff.deadline < best_dl_ff ||
                   (rd_data_ff.deadline == best_dl_ff && age > best_age_ff))) begin
                  best_fnd_in  = 1'b1;
                  best_idx_in  = chk_idx_ff;
                  best_dl_in   = rd_data_ff.deadline;
                  best_age_in  = age;
                  best_node_in = rd_data_ff.node;
               end
            end
            if (scan_done) begin
               case (cur_ff.req_type)
                  REQ_SET: begin
                     if (match_fnd_ff) begin
                        state_in = ST_DROP;
                     end else if (!cur_ff.has_time) begin
                        state_in = ST_IDLE;
                     end else begin
                        state_in = free_fnd_ff ? ST_ADD : ST_FULL;
                     end
                  end
                  REQ_DESTROY: state_in = match_fnd_ff ? ST_DROP : ST_IDLE;
                  REQ_FAILED: begin
                     if (match_fnd_ff || !cur_ff.has_time) begin
                        state_in = ST_IDLE;
                     end else begin
                        state_in = free_fnd_ff ? ST_ADD : ST_FULL;
                     end
                  end
                  REQ_CHECK: begin
                     if (best_fnd_ff && best_dl_ff <= cur_ff.now) begin
                        state_in = ST_TAKE;
                     end else begin
                        state_in = pend_vld_ff ? ST_FINAL : ST_IDLE;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_DROP: begin
            mem_we    = 1'b1;
            mem_waddr = match_idx_ff;
            if (cur_ff.req_type == REQ_SET && cur_ff.has_time) begin
               state_in = slot_fnd ? ST_ADD : ST_FULL;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_ADD: begin
            mem_we             = 1'b1;
            mem_waddr          = slot_idx;
            mem_wdata.valid    = 1'b1;
            mem_wdata.node     = cur_ff.node_id;
            mem_wdata.deadline = cand_dl_ff;
            mem_wdata.order    = order_ctr_ff;
            order_ctr_in       = order_ctr_ff + 1'b1;
            state_in           = ST_IDLE;
         end
         ST_FULL: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_item_in.out_node_id = cur_ff.node_id;
               rsp_item_in.status      = STATUS_FULL;
               rsp_item_in.last        = 1'b1;
               state_in                = ST_IDLE;
            end
         end
         ST_TAKE: begin
            if (!pend_vld_ff || out_free) begin
               if (pend_vld_ff) begin
                  rsp_valid_in            = 1'b1;
                  rsp_item_in.out_node_id = pend_node_ff;
                  rsp_item_in.status      = STATUS_EXPIRED;
                  rsp_item_in.last        = 1'b0;
               end
               pend_vld_in  = 1'b1;
               pend_node_in = best_node_ff;
               mem_we       = 1'b1;
               mem_waddr    = best_idx_ff;
               count_in     = count_ff + 1'b1;
               if (count_ff + 1'b1 == limit) begin
                  state_in = ST_FINAL;
               end else begin
                  start_scan = 1'b1;
               end
            end
         end
         ST_FINAL: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_item_in.out_node_id = pend_node_ff;
               rsp_item_in.status      = STATUS_EXPIRED;
               rsp_item_in.last        = 1'b1;
               pend_vld_in             = 1'b0;
               state_in                = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (start_scan) begin
         state_in     = ST_SCAN;
         iss_in       = '0;
         chk_vld_in   = 1'b0;
         match_fnd_in = 1'b0;
         free_fnd_in  = 1'b0;
         best_fnd_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         iss_ff       <= '0;
         chk_vld_ff   <= 1'b0;
         match_fnd_ff <= 1'b0;
         free_fnd_ff  <= 1'b0;
         best_fnd_ff  <= 1'b0;
         pend_vld_ff  <= 1'b0;
         count_ff     <= '0;
         order_ctr_ff <= '0;
         max_rem_ff   <= MAX_REMOVALS_RST;
         backoff_ff   <= BACKOFF_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         iss_ff       <= iss_in;
         chk_vld_ff   <= chk_vld_in;
         match_fnd_ff <= match_fnd_in;
         free_fnd_ff  <= free_fnd_in;
         best_fnd_ff  <= best_fnd_in;
         pend_vld_ff  <= pend_vld_in;
         count_ff     <= count_in;
         order_ctr_ff <= order_ctr_in;
         max_rem_ff   <= max_rem_in;
         backoff_ff   <= backoff_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      cand_dl_ff   <= cand_dl_in;
      chk_idx_ff   <= chk_idx_in;
      match_idx_ff <= match_idx_in;
      free_idx_ff  <= free_idx_in;
      best_idx_ff  <= best_idx_in;
      best_dl_ff   <= best_dl_in;
      best_age_ff  <= best_age_in;
      best_node_ff <= best_node_in;
      pend_node_ff <= pend_node_in;
      rsp_item_ff  <= rsp_item_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= entry_mem[iss_ff[AW-1:0]];
   end

`ifndef SYNTH
   a_full_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_item_ff.status == STATUS_FULL) |-> rsp_item_ff.last)
      else $error("table-full result without last");

   a_batch_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (count_ff <= LIM_W'(MAX_BATCH)))
      else $error("batch count beyond limit");

   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !rsp_valid_ff)
      else $error("result during clearing pass");
`endif

endmodule
